>>> rtl/core/console_line_editor_macros.svh
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// Clocked check, off while reset is low.
// Clocked check, also active during reset.
`ifndef SYNTHESIS
`define CLE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("console_line_editor: check failed");
`define CLE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("console_line_editor: check failed");
`else
`define CLE_ASSERT(label, clk, rst_n, prop)
`define CLE_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/core/cle_pkg.sv
package cle_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
  localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(LINE_CAPACITY);

  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 7;
  localparam int EV_W       = 2;
  localparam int ECHO_CNT_W = 3;
  localparam int ECHO_NUM   = 4;
  localparam int LEN_W      = 7;
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = OP_W;
  localparam int OUT_FILL_W  = 4;
  localparam int OUT_TDATA_W = EV_W + ECHO_CNT_W + ECHO_NUM * BYTE_W + LEN_W + BYTE_W
                               + OUT_FILL_W;

  localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_UC_C  = 8'h43;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

  localparam logic [ECHO_CNT_W-1:0] ECHO_NONE   = 3'd0;
  localparam logic [ECHO_CNT_W-1:0] ECHO_BYTE   = 3'd1;
  localparam logic [ECHO_CNT_W-1:0] ECHO_EOL    = 3'd2;
  localparam logic [ECHO_CNT_W-1:0] ECHO_RUBOUT = 3'd3;
  localparam logic [ECHO_CNT_W-1:0] ECHO_CANCEL = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_FEED    = 2'd0,
    OP_READ    = 2'd1,
    OP_DISCARD = 2'd2
  } op_e;

  typedef enum logic [EV_W-1:0] {
    EV_NONE      = 2'd0,
    EV_READY     = 2'd1,
    EV_REJECTED  = 2'd2,
    EV_CANCELLED = 2'd3
  } event_e;

  typedef struct packed {
    event_e                           ev;
    logic [ECHO_CNT_W-1:0]            echo_cnt;
    logic [ECHO_NUM-1:0][BYTE_W-1:0]  echo;
    logic [LEN_W-1:0]                 length;
    logic                             rd_hit;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

>>> rtl/core/cle_ram.sv
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 127
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/cle_edit.sv
module cle_edit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  cle_pkg::op_e              op_i,
  input  logic [cle_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic [cle_pkg::IDX_W-1:0]  read_index_i,
  output cle_pkg::result_t          res_o,
  output cle_pkg::ram_req_t         ram_o
);

  import cle_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rej_q, rej_d;
  logic             comp_q, comp_d;
  logic             cr_q, cr_d;
  result_t          res;
  ram_req_t         ram;
  logic             legal;

  assign legal = rx_byte_i inside {CH_TAB, [CH_SPACE:CH_TILDE]};

  always_comb begin
    cnt_d        = cnt_q;
    rej_d        = rej_q;
    comp_d       = comp_q;
    cr_d         = cr_q;
    res.ev       = EV_NONE;
    res.echo_cnt = ECHO_NONE;
    res.echo     = '0;
    res.rd_hit   = 1'b0;
    ram          = '0;
    case (op_i)
      OP_FEED: begin
        if (comp_q) begin
          cnt_d  = '0;
          rej_d  = 1'b0;
          comp_d = 1'b0;
        end
        if (rx_byte_i == CH_LF && cr_q) begin
          cr_d = 1'b0;
        end else begin
          cr_d = (rx_byte_i == CH_CR);
          if (rx_byte_i == CH_ETX) begin
            cnt_d        = '0;
            rej_d        = 1'b0;
            res.ev       = EV_CANCELLED;
            res.echo_cnt = ECHO_CANCEL;
            res.echo     = {CH_LF, CH_CR, CH_UC_C, CH_CARET};
          end else if (rx_byte_i == CH_CR || rx_byte_i == CH_LF) begin
            comp_d       = 1'b1;
            res.ev       = rej_d ? EV_REJECTED : EV_READY;
            res.echo_cnt = ECHO_EOL;
            res.echo     = {8'h00, 8'h00, CH_LF, CH_CR};
          end else if (rej_d) begin
            res.ev = EV_NONE;
          end else if (rx_byte_i == CH_BS || rx_byte_i == CH_DEL) begin
            if (cnt_d != '0) begin
              cnt_d        = cnt_d - 1'b1;
              res.echo_cnt = ECHO_RUBOUT;
              res.echo     = {8'h00, CH_BS, CH_SPACE, CH_BS};
            end
          end else if (!legal || cnt_d >= CNT_W'(STORE_DEPTH)) begin
            cnt_d  = '0;
            rej_d  = 1'b1;
            comp_d = 1'b0;
            cr_d   = 1'b0;
          end else begin
            ram.we       = 1'b1;
            ram.waddr    = cnt_d[ADDR_W-1:0];
            ram.wdata    = rx_byte_i;
            cnt_d        = cnt_d + 1'b1;
            res.echo_cnt = ECHO_BYTE;
            res.echo[0]  = (rx_byte_i == CH_TAB) ? CH_SPACE : rx_byte_i;
          end
        end
      end
      OP_READ: begin
        ram.re     = 1'b1;
        ram.raddr  = ADDR_W'(read_index_i);
        res.rd_hit = CMP_W'(read_index_i) < CMP_W'(cnt_q);
      end
      OP_DISCARD: begin
        cnt_d  = '0;
        rej_d  = 1'b1;
        comp_d = 1'b0;
        cr_d   = 1'b0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
    res.length = LEN_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rej_q  <= 1'b0;
      comp_q <= 1'b0;
      cr_q   <= 1'b0;
    end else if (accept_i) begin
      cnt_q  <= cnt_d;
      rej_q  <= rej_d;
      comp_q <= comp_d;
      cr_q   <= cr_d;
    end
  end

  assign res_o    = res;
  assign ram_o.we    = ram.we & accept_i;
  assign ram_o.re    = ram.re & accept_i;
  assign ram_o.waddr = ram.waddr;
  assign ram_o.wdata = ram.wdata;
  assign ram_o.raddr = ram.raddr;

endmodule

>>> rtl/core/console_line_editor.sv
// Console line editor: one request per clock, full throughput unless stalled by
// the output. A request is decoded and the edit state updated in the cycle it is
// accepted; the line store (LINE_CAPACITY-1 bytes) is a RAM with one write and
// one registered read port, so a read request's byte is registered in the RAM,
// and the result passes through the stage-1 register into the output register.
// Writes and reads never coincide, as a request is either a feed or a read.
// No clearing pass after reset: read data is passed on only for bytes below the
// current length, all of which have been written. Back-pressure on the output
// stalls the input only once both internal stages are full.
module console_line_editor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // rx_byte [7:0], read_index [14:8], zero fill [15]
  input  logic [cle_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // operation [1:0]
  input  logic [cle_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // event_res [1:0], echo_count [4:2], echo_first [12:5], echo_second [20:13],
  // echo_third [28:21], echo_fourth [36:29], line_length [43:37],
  // read_data [51:44], zero fill [55:52]
  output logic [cle_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import cle_pkg::*;

`include "console_line_editor_macros.svh"

  logic                   accept;
  logic                   s1_adv;
  logic                   s1_valid_q;
  result_t                s1_res_q;
  result_t                res;
  ram_req_t               ram_req;
  logic [BYTE_W-1:0]      rdata;
  logic [BYTE_W-1:0]      rd_byte;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cle_edit u_edit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (op_e'(s_axis_tuser)),
    .rx_byte_i    (s_axis_tdata[BYTE_W-1:0]),
    .read_index_i (s_axis_tdata[BYTE_W+IDX_W-1:BYTE_W]),
    .res_o        (res),
    .ram_o        (ram_req)
  );

  cle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  assign rd_byte    = s1_res_q.rd_hit ? rdata : '0;
  assign out_data_d = {{OUT_FILL_W{1'b0}}, rd_byte, s1_res_q.length,
                       s1_res_q.echo[3], s1_res_q.echo[2], s1_res_q.echo[1],
                       s1_res_q.echo[0], s1_res_q.echo_cnt, s1_res_q.ev};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `CLE_ASSERT_ALWAYS(a_ram_one_access, clk_i, !(ram_req.we && ram_req.re))
  `CLE_ASSERT(a_ready_when_out_empty, clk_i, rst_ni, !out_valid_q |-> s_axis_tready)
  `CLE_ASSERT(a_echo_count_range, clk_i, rst_ni, out_valid_q |-> (out_data_q[4:2] <= ECHO_CANCEL))
  `CLE_ASSERT(a_cancel_echo, clk_i, rst_ni, (out_valid_q && out_data_q[1:0] == EV_CANCELLED) |-> (out_data_q[4:2] == ECHO_CANCEL))

endmodule
